// File: sv/rsi_pkg.sv
// Shared types, constants and helpers for the ray against sphere intersection block.
package rsi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
	localparam int FRONT_STAGES = 5;
	localparam int SQRT_STEPS = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

	typedef logic signed [31:0] s32_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_MATERIAL = 3'd4
	} cfg_reg_t;

	// One ray as it arrives
	typedef struct packed {
		s32_t ox;
		s32_t oy;
		s32_t oz;
		s32_t dx;
		s32_t dy;
		s32_t dz;
		s32_t tlo;
		s32_t thi;
	} ray_t;

	// Classified ray handed from the front to the back
	typedef struct packed {
		ray_t        ray;
		s32_t        a;
		s32_t        b;
		logic [63:0] disc;
		logic        go;
	} fq_t;

	// Tag carried alongside the normal x division
	typedef struct packed {
		logic hit;
		s32_t t;
		s32_t px;
	} ntag_t;

	// Clamp a wide signed value to the signed 32-bit range
	function automatic s32_t sat_s32(input logic signed [65:0] v);
		s32_t r;
		if (v > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: sv/ray_sphere_intersect.sv
// Top level of the ray against sphere intersection block.
// One ray is taken per clock when start is high and busy is low, and each ray gives exactly
// one result beat on done, in arrival order. The back part holds the 32-step square root
// pipeline and two divider pipelines (the root division and the normal division). busy only
// rises if the queue between front and back could overflow; as the back drains a beat every
// cycle it stays low in normal use, so rays may be issued every cycle. The receiver cannot
// stall: capture each result in the cycle that done is high. Write the sphere registers only
// while no ray is in flight.
module ray_sphere_intersect #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [31:0]               origin_x,
	input  logic signed [31:0]               origin_y,
	input  logic signed [31:0]               origin_z,
	input  logic signed [31:0]               dir_x,
	input  logic signed [31:0]               dir_y,
	input  logic signed [31:0]               dir_z,
	input  logic signed [31:0]               t_lower,
	input  logic signed [31:0]               t_upper,
	input  logic                             cfg_we,
	input  logic [rsi_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [31:0]                      cfg_wdata,
	output logic                             done,
	output logic                             is_hit,
	output logic signed [31:0]               hit_t,
	output logic signed [31:0]               point_x,
	output logic signed [31:0]               point_y,
	output logic signed [31:0]               point_z,
	output logic signed [31:0]               normal_x,
	output logic signed [31:0]               normal_y,
	output logic signed [31:0]               normal_z,
	output logic [15:0]                      hit_material
);

	rsi_pkg::s32_t center_x_q, center_y_q, center_z_q;
	logic [30:0]   radius_q;
	logic [15:0]   material_q;

	rsi_pkg::ray_t ray_in;
	logic          take;
	logic          front_push;
	rsi_pkg::fq_t  front_entry;
	logic [2:0]    front_inflight;
	logic          fifo_vld;
	rsi_pkg::fq_t  fifo_dout;
	logic [rsi_pkg::FIFO_CNT_W-1:0] fifo_cnt;

	// Sphere registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q <= 31'd65536;
			material_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rsi_pkg::REG_CENTER_X: center_x_q <= $signed(cfg_wdata);
				rsi_pkg::REG_CENTER_Y: center_y_q <= $signed(cfg_wdata);
				rsi_pkg::REG_CENTER_Z: center_z_q <= $signed(cfg_wdata);
				rsi_pkg::REG_RADIUS:   radius_q <= cfg_wdata[30:0];
				rsi_pkg::REG_MATERIAL: material_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Hold off new rays when the queue could not absorb everything in flight
	assign busy = (5'(fifo_cnt) + 5'(front_inflight)) >= 5'(rsi_pkg::FIFO_DEPTH);
	assign take = start & ~busy;

	assign ray_in.ox = origin_x;
	assign ray_in.oy = origin_y;
	assign ray_in.oz = origin_z;
	assign ray_in.dx = dir_x;
	assign ray_in.dy = dir_y;
	assign ray_in.dz = dir_z;
	assign ray_in.tlo = t_lower;
	assign ray_in.thi = t_upper;

	rsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.ray_in   (ray_in),
		.cx       (center_x_q),
		.cy       (center_y_q),
		.cz       (center_z_q),
		.radius   (radius_q),
		.push     (front_push),
		.entry    (front_entry),
		.inflight (front_inflight)
	);

	rsi_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.din    (front_entry),
		.vld_o  (fifo_vld),
		.dout   (fifo_dout),
		.count  (fifo_cnt)
	);

	rsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.vld_i        (fifo_vld),
		.fq_i         (fifo_dout),
		.cx           (center_x_q),
		.cy           (center_y_q),
		.cz           (center_z_q),
		.radius       (radius_q),
		.material     (material_q),
		.done         (done),
		.is_hit       (is_hit),
		.hit_t        (hit_t),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.hit_material (hit_material)
	);

	// The queue never takes a beat when full
	a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_cnt == rsi_pkg::FIFO_CNT_W'(rsi_pkg::FIFO_DEPTH)) |-> !front_push)
		else $error("queue written while full");

	// A miss carries an all-zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_hit) |-> (hit_t == '0 && point_x == '0 && normal_x == '0
			&& hit_material == '0))
		else $error("miss result not cleared");

	// A hit carries the sphere's material tag
	a_hit_material: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_hit) |-> (hit_material == material_q))
		else $error("hit material mismatch");

endmodule

// File: sv/rsi_front.sv
// Front part: offsets, quadratic coefficients, discriminant and classification.
module rsi_front #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  rsi_pkg::ray_t       ray_in,
	input  rsi_pkg::s32_t       cx,
	input  rsi_pkg::s32_t       cy,
	input  rsi_pkg::s32_t       cz,
	input  logic [30:0]         radius,
	output logic                push,
	output rsi_pkg::fq_t        entry,
	output logic [2:0]          inflight
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	rsi_pkg::ray_t ray_s1, ray_s2, ray_s3, ray_s4;
	rsi_pkg::s32_t oc_s1 [3];
	rsi_pkg::s32_t oc_n [3];
	rsi_pkg::s32_t d1 [3];

	logic signed [63:0] dd_s2 [3];
	logic signed [63:0] od_s2 [3];
	logic signed [63:0] oo_s2 [3];
	logic signed [63:0] rr_s2;

	rsi_pkg::s32_t a_s3, b_s3, c_s3;
	rsi_pkg::s32_t a_s4, b_s4;
	logic signed [63:0] bb_s4, ac_s4;
	logic signed [64:0] disc_n;

	rsi_pkg::fq_t entry_s5;

	// Valid chain through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Offset of the origin from the centre, clamped
	always_comb begin
		oc_n[0] = rsi_pkg::sat_s32(66'(ray_in.ox) - 66'(cx));
		oc_n[1] = rsi_pkg::sat_s32(66'(ray_in.oy) - 66'(cy));
		oc_n[2] = rsi_pkg::sat_s32(66'(ray_in.oz) - 66'(cz));
		d1[0] = ray_s1.dx;
		d1[1] = ray_s1.dy;
		d1[2] = ray_s1.dz;
	end

	always_ff @(posedge clk) begin
		ray_s1 <= ray_in;
		for (int k = 0; k < 3; k++) begin
			oc_s1[k] <= oc_n[k];
		end
	end

	// Products for the dot products, scaled back to fixed point
	always_ff @(posedge clk) begin
		ray_s2 <= ray_s1;
		for (int k = 0; k < 3; k++) begin
			dd_s2[k] <= (64'(d1[k]) * 64'(d1[k])) >>> FRAC_BITS;
			od_s2[k] <= (64'(oc_s1[k]) * 64'(d1[k])) >>> FRAC_BITS;
			oo_s2[k] <= (64'(oc_s1[k]) * 64'(oc_s1[k])) >>> FRAC_BITS;
		end
		rr_s2 <= (64'($signed({1'b0, radius})) * 64'($signed({1'b0, radius}))) >>> FRAC_BITS;
	end

	// Sum into the clamped coefficients
	always_ff @(posedge clk) begin
		ray_s3 <= ray_s2;
		a_s3 <= rsi_pkg::sat_s32(66'(dd_s2[0]) + 66'(dd_s2[1]) + 66'(dd_s2[2]));
		b_s3 <= rsi_pkg::sat_s32(66'(od_s2[0]) + 66'(od_s2[1]) + 66'(od_s2[2]));
		c_s3 <= rsi_pkg::sat_s32(66'(oo_s2[0]) + 66'(oo_s2[1]) + 66'(oo_s2[2])
			- 66'(rr_s2));
	end

	// Discriminant products
	always_ff @(posedge clk) begin
		ray_s4 <= ray_s3;
		a_s4 <= a_s3;
		b_s4 <= b_s3;
		bb_s4 <= 64'(b_s3) * 64'(b_s3);
		ac_s4 <= 64'(a_s3) * 64'(c_s3);
	end

	// Discriminant and classification
	assign disc_n = 65'(bb_s4) - 65'(ac_s4);

	always_ff @(posedge clk) begin
		entry_s5.ray <= ray_s4;
		entry_s5.a <= a_s4;
		entry_s5.b <= b_s4;
		entry_s5.disc <= disc_n[63:0];
		entry_s5.go <= (a_s4 > 32'sd0) && (disc_n > 65'sd0);
	end

	assign push = v_s5;
	assign entry = entry_s5;
	assign inflight = 3'({2'b00, v_s1}) + 3'({2'b00, v_s2}) + 3'({2'b00, v_s3})
		+ 3'({2'b00, v_s4}) + 3'({2'b00, v_s5});

endmodule

// File: sv/rsi_fifo.sv
// Short queue between the front and the back, with a registered read port.
module rsi_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  rsi_pkg::fq_t                       din,
	output logic                               vld_o,
	output rsi_pkg::fq_t                       dout,
	output logic [rsi_pkg::FIFO_CNT_W-1:0]     count
);

	rsi_pkg::fq_t mem [rsi_pkg::FIFO_DEPTH];

	logic [rsi_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rsi_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic vld_q;
	logic pop;

	// The back drains one beat every cycle while the queue is not empty
	assign pop = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dout <= mem[rd_ptr_q];
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + rsi_pkg::FIFO_CNT_W'(push) - rsi_pkg::FIFO_CNT_W'(pop);
			vld_q <= pop;
		end
	end

	assign vld_o = vld_q;
	assign count = cnt_q;

endmodule

// File: sv/rsi_div.sv
// Pipelined restoring divider: signed numerator over unsigned divisor, clamped to 32 bits.
module rsi_div #(
	parameter int NW = 51,
	parameter int PW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_i,
	input  logic signed [NW-1:0] num_i,
	input  logic [31:0]          den_i,
	input  logic [PW-1:0]        pay_i,
	output logic                 vld_o,
	output rsi_pkg::s32_t        q_o,
	output logic [PW-1:0]        pay_o
);

	localparam int QW = 32;
	localparam int HW = NW - QW;

	logic [NW-1:0] mag;
	logic [HW-1:0] hi;

	logic          v_s [0:QW];
	logic [31:0]   rem_s [0:QW];
	logic [31:0]   lo_s [0:QW];
	logic [31:0]   q_s [0:QW];
	logic [31:0]   den_s [0:QW];
	logic          neg_s [0:QW];
	logic          ovf_s [0:QW];
	logic [PW-1:0] pay_s [0:QW];

	logic [31:0]   rem_n [0:QW-1];
	logic [31:0]   q_n [0:QW-1];

	logic          v_q;
	rsi_pkg::s32_t q_q;
	logic [PW-1:0] pay_q;

	// Magnitude and overflow test of the input
	assign mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
	assign hi = mag[NW-1:QW];

	// One quotient bit per stage
	always_comb begin
		logic [32:0] rem2;
		for (int k = 0; k < QW; k++) begin
			rem2 = {rem_s[k], lo_s[k][31]};
			if (rem2 >= {1'b0, den_s[k]}) begin
				rem_n[k] = 32'(rem2 - {1'b0, den_s[k]});
				q_n[k] = {q_s[k][30:0], 1'b1};
			end else begin
				rem_n[k] = rem2[31:0];
				q_n[k] = {q_s[k][30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) begin
				v_s[k] <= 1'b0;
			end
			v_q <= 1'b0;
		end else begin
			v_s[0] <= vld_i;
			for (int k = 0; k < QW; k++) begin
				v_s[k+1] <= v_s[k];
			end
			v_q <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= 32'(hi);
		lo_s[0] <= mag[31:0];
		q_s[0] <= '0;
		den_s[0] <= den_i;
		neg_s[0] <= num_i[NW-1];
		ovf_s[0] <= (NW'(hi) >= NW'(den_i));
		pay_s[0] <= pay_i;
		for (int k = 0; k < QW; k++) begin
			rem_s[k+1] <= rem_n[k];
			lo_s[k+1] <= {lo_s[k][30:0], 1'b0};
			q_s[k+1] <= q_n[k];
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
			pay_s[k+1] <= pay_s[k];
		end
	end

	// Apply the sign and clamp
	always_ff @(posedge clk) begin
		pay_q <= pay_s[QW];
		if (ovf_s[QW]) begin
			q_q <= neg_s[QW] ? 32'sh80000000 : 32'sh7fffffff;
		end else if (neg_s[QW]) begin
			q_q <= (q_s[QW] > 32'h80000000) ? 32'sh80000000 : $signed(32'(0 - q_s[QW]));
		end else begin
			q_q <= (q_s[QW] > 32'h7fffffff) ? 32'sh7fffffff : $signed(q_s[QW]);
		end
	end

	assign vld_o = v_q;
	assign q_o = q_q;
	assign pay_o = pay_q;

endmodule

// File: sv/rsi_back.sv
// Back part: square root, root divisions, interval test, hit point and normal.
module rsi_back #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_i,
	input  rsi_pkg::fq_t  fq_i,
	input  rsi_pkg::s32_t cx,
	input  rsi_pkg::s32_t cy,
	input  rsi_pkg::s32_t cz,
	input  logic [30:0]   radius,
	input  logic [15:0]   material,
	output logic          done,
	output logic          is_hit,
	output rsi_pkg::s32_t hit_t,
	output rsi_pkg::s32_t point_x,
	output rsi_pkg::s32_t point_y,
	output rsi_pkg::s32_t point_z,
	output rsi_pkg::s32_t normal_x,
	output rsi_pkg::s32_t normal_y,
	output rsi_pkg::s32_t normal_z,
	output logic [15:0]   hit_material
);

	localparam int SN = rsi_pkg::SQRT_STEPS;
	localparam int NW = 35 + FRAC_BITS;
	localparam int NNW = 33 + FRAC_BITS;
	localparam int RPW = $bits(rsi_pkg::ray_t);
	localparam int TPW = $bits(rsi_pkg::ntag_t);

	// Square root stages
	logic         sq_v_s [1:SN];
	logic [63:0]  sq_x_s [1:SN];
	logic [63:0]  sq_r_s [1:SN];
	rsi_pkg::fq_t sq_p_s [1:SN];

	logic [63:0]  cur_x [0:SN-1];
	logic [63:0]  cur_r [0:SN-1];
	rsi_pkg::fq_t cur_p [0:SN-1];
	logic [63:0]  nx_x [0:SN-1];
	logic [63:0]  nx_r [0:SN-1];

	// Numerator stage
	logic                 v_s1;
	logic signed [NW-1:0] num_n_s1, num_f_s1;
	logic [31:0]          den_s1;
	rsi_pkg::ray_t        ray_s1;
	logic                 go_s1;
	logic signed [34:0]   near_n, far_n;
	logic [32:0]          sq_root;

	// Root division outputs
	logic          vn, vf;
	rsi_pkg::s32_t qn, qf;
	logic [RPW-1:0] pn;
	logic [0:0]    pf;
	rsi_pkg::ray_t ray_d;
	logic          in_near, in_far;

	// Select, multiply, point stages
	logic          v_s2, v_s3, v_s4, v_s5, v_s6;
	logic          hit_s2, hit_s3, hit_s4;
	rsi_pkg::s32_t t_s2, t_s3, t_s4;
	rsi_pkg::ray_t ray_s2;
	rsi_pkg::s32_t o_s3 [3];
	logic signed [63:0] m_s3 [3];
	rsi_pkg::s32_t p_s4 [3];
	rsi_pkg::s32_t ce [3];

	// Normal numerator stage
	logic signed [NNW-1:0] nn_s5 [3];
	rsi_pkg::ntag_t        tag_s5;
	rsi_pkg::s32_t         py_s5, pz_s5;

	// Normal division outputs
	logic           vx, vy, vz;
	rsi_pkg::s32_t  nqx, nqy, nqz;
	logic [TPW-1:0] ptx;
	logic [31:0]    pty, ptz;
	rsi_pkg::ntag_t tag_d;

	// Output stage
	logic          hit_s6;
	rsi_pkg::s32_t t_s6, px_s6, py_s6, pz_s6, nx_s6, ny_s6, nz_s6;
	logic [15:0]   mat_s6;

	assign ce[0] = cx;
	assign ce[1] = cy;
	assign ce[2] = cz;

	// Integer square root, one result bit per stage
	always_comb begin
		logic [63:0] trial;
		cur_x[0] = fq_i.disc;
		cur_r[0] = '0;
		cur_p[0] = fq_i;
		for (int k = 1; k < SN; k++) begin
			cur_x[k] = sq_x_s[k];
			cur_r[k] = sq_r_s[k];
			cur_p[k] = sq_p_s[k];
		end
		for (int k = 0; k < SN; k++) begin
			trial = cur_r[k] + (64'd1 << (62 - 2 * k));
			if (cur_x[k] >= trial) begin
				nx_x[k] = cur_x[k] - trial;
				nx_r[k] = (cur_r[k] >> 1) + (64'd1 << (62 - 2 * k));
			end else begin
				nx_x[k] = cur_x[k];
				nx_r[k] = cur_r[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SN; k++) begin
			sq_x_s[k+1] <= nx_x[k];
			sq_r_s[k+1] <= nx_r[k];
			sq_p_s[k+1] <= cur_p[k];
		end
	end

	// Valid chain through the back's own stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= SN; k++) begin
				sq_v_s[k] <= 1'b0;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			sq_v_s[1] <= vld_i;
			for (int k = 1; k < SN; k++) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
			v_s1 <= sq_v_s[SN];
			v_s2 <= vn & vf;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= vx & vy & vz;
		end
	end

	// Root numerators, scaled up for the division
	assign sq_root = sq_r_s[SN][32:0];
	assign near_n = -35'(sq_p_s[SN].b) - $signed({2'b00, sq_root});
	assign far_n = -35'(sq_p_s[SN].b) + $signed({2'b00, sq_root});

	always_ff @(posedge clk) begin
		num_n_s1 <= NW'(near_n) <<< FRAC_BITS;
		num_f_s1 <= NW'(far_n) <<< FRAC_BITS;
		den_s1 <= sq_p_s[SN].a;
		ray_s1 <= sq_p_s[SN].ray;
		go_s1 <= sq_p_s[SN].go;
	end

	rsi_div #(.NW(NW), .PW(RPW)) u_div_near (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (v_s1),
		.num_i  (num_n_s1),
		.den_i  (den_s1),
		.pay_i  (ray_s1),
		.vld_o  (vn),
		.q_o    (qn),
		.pay_o  (pn)
	);

	rsi_div #(.NW(NW), .PW(1)) u_div_far (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (v_s1),
		.num_i  (num_f_s1),
		.den_i  (den_s1),
		.pay_i  (go_s1),
		.vld_o  (vf),
		.q_o    (qf),
		.pay_o  (pf)
	);

	// Take the near root if it lies in the open interval, else the far one
	assign ray_d = rsi_pkg::ray_t'(pn);
	assign in_near = (qn > ray_d.tlo) && (qn < ray_d.thi);
	assign in_far = (qf > ray_d.tlo) && (qf < ray_d.thi);

	always_ff @(posedge clk) begin
		hit_s2 <= pf[0] & (in_near | in_far);
		t_s2 <= in_near ? qn : qf;
		ray_s2 <= ray_d;
	end

	// Step along the ray
	always_ff @(posedge clk) begin
		hit_s3 <= hit_s2;
		t_s3 <= t_s2;
		o_s3[0] <= ray_s2.ox;
		o_s3[1] <= ray_s2.oy;
		o_s3[2] <= ray_s2.oz;
		m_s3[0] <= 64'(t_s2) * 64'(ray_s2.dx);
		m_s3[1] <= 64'(t_s2) * 64'(ray_s2.dy);
		m_s3[2] <= 64'(t_s2) * 64'(ray_s2.dz);
	end

	always_ff @(posedge clk) begin
		hit_s4 <= hit_s3;
		t_s4 <= t_s3;
		for (int k = 0; k < 3; k++) begin
			p_s4[k] <= rsi_pkg::sat_s32(66'(o_s3[k]) + 66'(m_s3[k] >>> FRAC_BITS));
		end
	end

	// Offset of the hit point from the centre, scaled up
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			nn_s5[k] <= NNW'($signed(33'(p_s4[k]) - 33'(ce[k]))) <<< FRAC_BITS;
		end
		tag_s5.hit <= hit_s4;
		tag_s5.t <= t_s4;
		tag_s5.px <= p_s4[0];
		py_s5 <= p_s4[1];
		pz_s5 <= p_s4[2];
	end

	rsi_div #(.NW(NNW), .PW(TPW)) u_div_nx (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (v_s5),
		.num_i  (nn_s5[0]),
		.den_i  ({1'b0, radius}),
		.pay_i  (tag_s5),
		.vld_o  (vx),
		.q_o    (nqx),
		.pay_o  (ptx)
	);

	rsi_div #(.NW(NNW), .PW(32)) u_div_ny (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (v_s5),
		.num_i  (nn_s5[1]),
		.den_i  ({1'b0, radius}),
		.pay_i  (py_s5),
		.vld_o  (vy),
		.q_o    (nqy),
		.pay_o  (pty)
	);

	rsi_div #(.NW(NNW), .PW(32)) u_div_nz (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (v_s5),
		.num_i  (nn_s5[2]),
		.den_i  ({1'b0, radius}),
		.pay_i  (pz_s5),
		.vld_o  (vz),
		.q_o    (nqz),
		.pay_o  (ptz)
	);

	// Form the result; drop everything to zero on a miss
	assign tag_d = rsi_pkg::ntag_t'(ptx);

	always_ff @(posedge clk) begin
		hit_s6 <= tag_d.hit;
		if (tag_d.hit) begin
			t_s6 <= tag_d.t;
			px_s6 <= tag_d.px;
			py_s6 <= $signed(pty);
			pz_s6 <= $signed(ptz);
			nx_s6 <= (radius == '0) ? '0 : nqx;
			ny_s6 <= (radius == '0) ? '0 : nqy;
			nz_s6 <= (radius == '0) ? '0 : nqz;
			mat_s6 <= material;
		end else begin
			t_s6 <= '0;
			px_s6 <= '0;
			py_s6 <= '0;
			pz_s6 <= '0;
			nx_s6 <= '0;
			ny_s6 <= '0;
			nz_s6 <= '0;
			mat_s6 <= '0;
		end
	end

	assign done = v_s6;
	assign is_hit = hit_s6;
	assign hit_t = t_s6;
	assign point_x = px_s6;
	assign point_y = py_s6;
	assign point_z = pz_s6;
	assign normal_x = nx_s6;
	assign normal_y = ny_s6;
	assign normal_z = nz_s6;
	assign hit_material = mat_s6;

endmodule

// File: sim/ray_sphere_intersect_tb.sv
// Self-checking testbench for the ray against sphere intersection block.
`timescale 1ns / 1ps

module ray_sphere_intersect_tb;

	localparam int FB = rsi_pkg::FRAC_BITS_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 160;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic          hit;
		rsi_pkg::s32_t t;
		rsi_pkg::s32_t px, py, pz;
		rsi_pkg::s32_t nx, ny, nz;
		logic [15:0]   mat;
	} hit_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	rsi_pkg::s32_t origin_x = '0, origin_y = '0, origin_z = '0;
	rsi_pkg::s32_t dir_x = '0, dir_y = '0, dir_z = '0;
	rsi_pkg::s32_t t_lower = '0, t_upper = '0;
	logic cfg_we = 1'b0;
	logic [rsi_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;
	logic done, is_hit;
	rsi_pkg::s32_t hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z;
	logic [15:0] hit_material;

	// sphere as the predictor sees it
	rsi_pkg::s32_t sph_cx = '0, sph_cy = '0, sph_cz = '0;
	logic [30:0] sph_rad = 31'd65536;
	logic [15:0] sph_mat = '0;

	hit_res_t pending_hits[$];
	int errors = 0;
	int quiet_cycles = 0;
	int gap_pct = 0;

	ray_sphere_intersect u_top (.*);

	always #4 clk = ~clk;

	function automatic wide_t clamp32(wide_t v);
		if (v > 128'sd2147483647) return 128'sd2147483647;
		if (v < -128'sd2147483648) return -128'sd2147483648;
		return v;
	endfunction

	function automatic wide_t qmul(wide_t x, wide_t y);
		return (x * y) >>> FB;
	endfunction

	function automatic wide_t root_floor(wide_t v);
		logic [63:0] x, res, bitv;
		x = v[63:0];
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return $signed({64'd0, res});
	endfunction

	// work out the intersection of one ray with the current sphere
	function automatic hit_res_t predict_hit(rsi_pkg::ray_t r);
		wide_t o[3], d[3], ce[3], oc[3];
		wide_t a, b, c, disc, s, t, p, rad, scale;
		hit_res_t res;
		logic hit;
		o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
		d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
		ce[0] = sph_cx; ce[1] = sph_cy; ce[2] = sph_cz;
		rad = $signed({97'd0, sph_rad});
		scale = wide_t'(1) <<< FB;
		for (int k = 0; k < 3; k++) oc[k] = clamp32(o[k] - ce[k]);
		a = clamp32(qmul(d[0], d[0]) + qmul(d[1], d[1]) + qmul(d[2], d[2]));
		b = clamp32(qmul(oc[0], d[0]) + qmul(oc[1], d[1]) + qmul(oc[2], d[2]));
		c = clamp32(qmul(oc[0], oc[0]) + qmul(oc[1], oc[1]) + qmul(oc[2], oc[2])
			- qmul(rad, rad));
		disc = b * b - a * c;
		hit = 1'b0;
		t = 0;
		if (a > 0 && disc > 0) begin
			s = root_floor(disc);
			t = clamp32(((-b - s) * scale) / a);
			if (t < r.thi && t > r.tlo) begin
				hit = 1'b1;
			end else begin
				t = clamp32(((-b + s) * scale) / a);
				hit = (t < r.thi && t > r.tlo);
			end
		end
		res = '{default: '0};
		if (hit) begin
			res.hit = 1'b1;
			res.t = t[31:0];
			res.mat = sph_mat;
			for (int k = 0; k < 3; k++) begin
				rsi_pkg::s32_t pv, nv;
				p = clamp32(o[k] + qmul(t, d[k]));
				pv = p[31:0];
				nv = '0;
				if (sph_rad != 0) nv = rsi_pkg::s32_t'(clamp32(((p - ce[k]) * scale) / rad));
				case (k)
					0: begin res.px = pv; res.nx = nv; end
					1: begin res.py = pv; res.ny = nv; end
					default: begin res.pz = pv; res.nz = nv; end
				endcase
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("[%0t] mismatch on %s: got %08h, expected %08h", $time, field, got, want);
	endtask

	// count cycles in which no beat moves on either side
	always @(posedge clk) begin
		if ((arst_n && done) || (start && !busy)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// check each result beat against the oldest prediction
	always @(posedge clk) begin
		hit_res_t w;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				errors++;
				$display("[%0t] result beat with nothing pending", $time);
			end else begin
				w = pending_hits.pop_front();
				if (is_hit !== w.hit) report_mismatch("is_hit", is_hit, w.hit);
				if (hit_t !== w.t) report_mismatch("hit_t", hit_t, w.t);
				if (point_x !== w.px) report_mismatch("point_x", point_x, w.px);
				if (point_y !== w.py) report_mismatch("point_y", point_y, w.py);
				if (point_z !== w.pz) report_mismatch("point_z", point_z, w.pz);
				if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
				if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
				if (normal_z !== w.nz) report_mismatch("normal_z", normal_z, w.nz);
				if (hit_material !== w.mat)
					report_mismatch("hit_material", hit_material, w.mat);
			end
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// send one ray beat, hold until accepted, then maybe idle
	task automatic send_ray(rsi_pkg::ray_t r);
		int gap;
		start <= 1'b1;
		origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
		dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
		t_lower <= r.tlo; t_upper <= r.thi;
		do @(posedge clk); while (busy);
		pending_hits.push_back(predict_hit(r));
		if ($urandom_range(99) < gap_pct) begin
			gap = $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(rsi_pkg::cfg_reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rsi_pkg::REG_CENTER_X: sph_cx = val;
			rsi_pkg::REG_CENTER_Y: sph_cy = val;
			rsi_pkg::REG_CENTER_Z: sph_cz = val;
			rsi_pkg::REG_RADIUS:   sph_rad = val[30:0];
			default:               sph_mat = val[15:0];
		endcase
	endtask

	// drop start and wait for every pending result plus pipeline slack
	task automatic drain();
		start <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_sphere(rsi_pkg::s32_t cx, rsi_pkg::s32_t cy, rsi_pkg::s32_t cz,
		logic [30:0] r, logic [15:0] m);
		write_reg(rsi_pkg::REG_CENTER_X, cx);
		write_reg(rsi_pkg::REG_CENTER_Y, cy);
		write_reg(rsi_pkg::REG_CENTER_Z, cz);
		write_reg(rsi_pkg::REG_RADIUS, {1'b0, r});
		write_reg(rsi_pkg::REG_MATERIAL, {16'd0, m});
	endtask

	function automatic rsi_pkg::ray_t mk_ray(rsi_pkg::s32_t ox, rsi_pkg::s32_t oy,
		rsi_pkg::s32_t oz, rsi_pkg::s32_t dx, rsi_pkg::s32_t dy, rsi_pkg::s32_t dz,
		rsi_pkg::s32_t tlo, rsi_pkg::s32_t thi);
		rsi_pkg::ray_t r;
		r.ox = ox; r.oy = oy; r.oz = oz;
		r.dx = dx; r.dy = dy; r.dz = dz;
		r.tlo = tlo; r.thi = thi;
		return r;
	endfunction

	function automatic rsi_pkg::s32_t rnd_q(int span);
		return rsi_pkg::s32_t'($signed($urandom_range(0, 2 * span * 65536)) - span * 65536);
	endfunction

	// ray aimed roughly at the current sphere, small values
	function automatic rsi_pkg::ray_t aimed_ray();
		rsi_pkg::ray_t r;
		r.ox = sph_cx + rnd_q(40);
		r.oy = sph_cy + rnd_q(40);
		r.oz = sph_cz + rnd_q(40);
		r.dx = ((sph_cx - r.ox) >>> $urandom_range(2, 5)) + rnd_q(1);
		r.dy = ((sph_cy - r.oy) >>> $urandom_range(2, 5)) + rnd_q(1);
		r.dz = ((sph_cz - r.oz) >>> $urandom_range(2, 5)) + rnd_q(1);
		if ($urandom_range(3) == 0) begin
			r.dx = -r.dx; r.dy = -r.dy; r.dz = -r.dz;
		end
		r.tlo = ($urandom_range(3) == 0) ? rnd_q(30) : 32'sd0;
		r.thi = ($urandom_range(7) == 0) ? rnd_q(30) : 32'sh7fffffff;
		return r;
	endfunction

	function automatic rsi_pkg::ray_t noise_ray();
		return mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
	endfunction

	// zero direction, tangent, reversed interval, near and far root, extremes
	task automatic test_directed_cases();
		localparam rsi_pkg::s32_t ONE = 32'sd65536;
		localparam rsi_pkg::s32_t MAXV = 32'sh7fffffff;
		localparam rsi_pkg::s32_t MINV = 32'sh80000000;
		send_ray(mk_ray(-5 * ONE, 0, 0, 0, 0, 0, 0, MAXV));
		send_ray(mk_ray(-5 * ONE, 0, 0, 1, 0, 0, 0, MAXV));
		send_ray(mk_ray(-5 * ONE, ONE, 0, ONE, 0, 0, 0, MAXV));
		send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0, MAXV));
		send_ray(mk_ray(-5 * ONE, 0, 0, -ONE, 0, 0, MINV, MAXV));
		send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0, 10 * ONE, 2 * ONE));
		send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0, 4 * ONE, 4 * ONE));
		send_ray(mk_ray(0, 0, 0, 0, ONE, 0, 0, MAXV));
		send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, ONE, 3 * ONE, MAXV));
		send_ray(mk_ray(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV));
		send_ray(mk_ray(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV));
		send_ray(mk_ray(MAXV, 0, 0, -ONE, 0, 0, MINV, MAXV));
		send_ray(mk_ray(0, 0, 0, MAXV, 0, 0, MINV, MAXV));
		send_ray(mk_ray(-1, -1, -1, -1, -1, -1, -1, -1));
		drain();
		// zero radius: rays aimed straight at the centre
		write_reg(rsi_pkg::REG_RADIUS, 32'd0);
		send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0, MINV, MAXV));
		send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0, MAXV));
		drain();
		// extreme sphere registers
		set_sphere(MAXV, MINV, MAXV, 31'h7fffffff, 16'hffff);
		send_ray(mk_ray(0, 0, 0, ONE, ONE, ONE, MINV, MAXV));
		send_ray(mk_ray(MAXV, MINV, MAXV, ONE, 0, 0, MINV, MAXV));
		send_ray(mk_ray(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV));
		drain();
	endtask

	// one random phase at a given sender idle rate
	task automatic test_random_phase(int pct, int count, rsi_pkg::s32_t span);
		gap_pct = pct;
		set_sphere(rnd_q(span), rnd_q(span), rnd_q(span),
			31'($urandom_range(32768, 20 * 65536)), 16'($urandom));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 75) send_ray(aimed_ray());
			else send_ray(noise_ray());
		end
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_phase(0, 180, 100);
		test_random_phase(55, 180, 20000);
		test_random_phase(28, 180, 5);
		test_random_phase(0, 160, 30000);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/rsi_pkg.sv
sv/rsi_front.sv
sv/rsi_fifo.sv
sv/rsi_div.sv
sv/rsi_back.sv
sv/ray_sphere_intersect.sv
sim/ray_sphere_intersect_tb.sv
